// ===== rtl/sclt_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sclt_pkg: shell command line tokenizer shared definitions
// Character codes, token kinds, scan modes and the records passed between
// the front, the queue and the back.
// ============================================================================
package sclt_pkg;

    localparam int LINE_MAX = 1024;
    localparam int POS_W    = $clog2(LINE_MAX + 1);   // 0..LINE_MAX
    localparam int START_W  = $clog2(LINE_MAX);       // 0..LINE_MAX-1
    localparam int LEN_W    = $clog2(LINE_MAX + 1);   // 1..LINE_MAX
    localparam int KIND_W   = 3;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_SQUOTE = 8'd39;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_BAR    = 8'd124;
    localparam logic [7:0] CH_LT     = 8'd60;
    localparam logic [7:0] CH_GT     = 8'd62;

    localparam logic [KIND_W-1:0] KIND_COMMAND = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PIPE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RIN     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ROUT    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_HEREDOC = 3'd4;
    localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd7;

    typedef enum logic [10:0] {
        M_IDLE    = 11'b000_0000_0001,
        M_BAR     = 11'b000_0000_0010,
        M_LT1     = 11'b000_0000_0100,
        M_LT2     = 11'b000_0000_1000,
        M_GT1     = 11'b000_0001_0000,
        M_GT2     = 11'b000_0010_0000,
        M_DQ_OPEN = 11'b000_0100_0000,
        M_DQ_BODY = 11'b000_1000_0000,
        M_SQ_OPEN = 11'b001_0000_0000,
        M_SQ_BODY = 11'b010_0000_0000,
        M_WORD    = 11'b100_0000_0000
    } mode_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
    } token_t;

    // Tokens caused by one byte: tok0 always valid, tok1 valid when two is set.
    typedef struct packed {
        logic   two;
        token_t tok0;
        token_t tok1;
    } step_t;

endpackage

// ===== rtl/sclt_ifs.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sclt channels: byte request channel and token request channel
// valid/ready handshake with the payload fields of each channel.
// ============================================================================
interface sclt_byte_if;
    import sclt_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       line_end;

    modport source (output valid, output char_in, output line_end, input ready);
    modport sink   (input valid, input char_in, input line_end, output ready);
endinterface

interface sclt_token_if;
    import sclt_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  token_kind;
    logic [START_W-1:0] token_start;
    logic [LEN_W-1:0]   token_length;
    logic               run_last;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output run_last, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input run_last, output ready);
endinterface

// ===== rtl/shell_command_line_tokenizer.sv =====
`timescale 1ns / 1ps
// ============================================================================
// shell_command_line_tokenizer: streaming tokenizer for shell command lines
// One byte per request in, one token per request out.
// ============================================================================
// Usage:
//   byte_ch  (sink)  : char_in, line_end. One byte of the line per request;
//                      line_end marks the last byte and flushes the pending
//                      token, then the offset count restarts at zero.
//   token_ch (source): token_kind, token_start, token_length, run_last.
//                      run_last is set on the last token a byte produced.
// Throughput: one byte per cycle while the step queue is not full. A byte
//   that completes two tokens gives two token requests; the four-entry
//   step queue absorbs such bursts. A token's record enters the queue when
//   its byte is accepted and then loads into the output register; a second
//   token of the same byte follows it.
// Reset (rst_n low, async): scan mode idle, offset and origin zero, queue
//   and output register empty.
// Stall: while token_ch.ready is low the output register holds its token;
//   the front keeps taking bytes until the queue fills, then drops
//   byte_ch.ready. Bytes that make no token never enter the queue.
// ============================================================================
module shell_command_line_tokenizer (
    input  logic          clk,
    input  logic          rst_n,
    sclt_byte_if.sink     byte_ch,
    sclt_token_if.source  token_ch
);
    import sclt_pkg::*;

    // front -> queue
    logic   q_push;
    step_t  q_data;
    logic   q_full;

    // queue -> back
    step_t  q_head;
    logic   q_empty;
    logic   q_pop;

    // Front: classifies bytes, tracks scan mode and offsets.
    sclt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_data)
    );

    // Decoupling queue of per-byte token records.
    sclt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // Back: serializes records into token requests.
    sclt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .empty    (q_empty),
        .pop      (q_pop),
        .token_ch (token_ch)
    );

endmodule

// ===== rtl/sclt_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sclt_front: byte classifier and scan state
// Takes one byte a cycle while the queue is not full, advances the scan mode
// and hands the tokens that the byte completes to the queue as one record.
// ============================================================================
module sclt_front (
    input  logic              clk,
    input  logic              rst_n,
    sclt_byte_if.sink         byte_ch,
    input  logic              q_full,
    output logic              q_push,
    output sclt_pkg::step_t   q_data
);
    import sclt_pkg::*;

    mode_t               mode_reg, mode_next, mode_mid;
    logic [POS_W-1:0]    pos_reg, pos_next, after;
    logic [START_W-1:0]  origin_reg, origin_next, origin_mid, origin_begin;
    logic                fire, start_tok;
    logic                a_valid, b_valid;
    logic [KIND_W-1:0]   a_kind, b_kind;
    logic [LEN_W-1:0]    a_len, b_len;
    logic [7:0]          c;

    function automatic mode_t begin_mode(input logic [7:0] ch);
        mode_t m;
        priority if (ch == CH_SPACE)  m = M_IDLE;
        else if (ch == CH_BAR)        m = M_BAR;
        else if (ch == CH_LT)         m = M_LT1;
        else if (ch == CH_GT)         m = M_GT1;
        else if (ch == CH_DQUOTE)     m = M_DQ_OPEN;
        else if (ch == CH_SQUOTE)     m = M_SQ_OPEN;
        else                          m = M_WORD;
        return m;
    endfunction

    // end - origin when positive, else 1
    function automatic logic [LEN_W-1:0] span(input logic [POS_W-1:0] e,
                                              input logic [START_W-1:0] o);
        logic [POS_W-1:0] oe;
        oe = {{(POS_W-START_W){1'b0}}, o};
        return (e > oe) ? LEN_W'(e - oe) : LEN_W'(1);
    endfunction

    assign c            = byte_ch.char_in;
    assign byte_ch.ready = !q_full;
    assign fire         = byte_ch.valid && !q_full;
    assign after        = (pos_reg < POS_W'(LINE_MAX)) ? pos_reg + POS_W'(1)
                                                       : POS_W'(LINE_MAX);
    assign origin_begin = (pos_reg < POS_W'(LINE_MAX - 1)) ? pos_reg[START_W-1:0]
                                                           : START_W'(LINE_MAX - 1);

    // Transition on the current byte; token A uses the old origin.
    always_comb
    begin
        mode_mid   = mode_reg;
        origin_mid = origin_reg;
        start_tok  = 1'b0;
        a_valid    = 1'b0;
        a_kind     = KIND_COMMAND;
        a_len      = LEN_W'(1);
        unique case (mode_reg)
            M_IDLE:    start_tok = 1'b1;
            M_BAR:
                if (c == CH_BAR) mode_mid = M_WORD;
                else
                begin
                    a_valid = 1'b1; a_kind = KIND_PIPE; start_tok = 1'b1;
                end
            M_LT1:
                if (c == CH_LT) mode_mid = M_LT2;
                else
                begin
                    a_valid = 1'b1; a_kind = KIND_RIN; start_tok = 1'b1;
                end
            M_LT2:
                if (c == CH_LT) mode_mid = M_WORD;
                else
                begin
                    a_valid = 1'b1; a_kind = KIND_HEREDOC; a_len = LEN_W'(2);
                    start_tok = 1'b1;
                end
            M_GT1:
                if (c == CH_GT) mode_mid = M_GT2;
                else
                begin
                    a_valid = 1'b1; a_kind = KIND_ROUT; start_tok = 1'b1;
                end
            M_GT2:
                if (c == CH_GT) mode_mid = M_WORD;
                else
                begin
                    a_valid = 1'b1; a_kind = KIND_APPEND; a_len = LEN_W'(2);
                    start_tok = 1'b1;
                end
            M_DQ_OPEN:
                if (c == CH_DQUOTE)
                begin
                    a_valid = 1'b1; a_kind = KIND_EMPTY; a_len = LEN_W'(2);
                    mode_mid = M_IDLE;
                end
                else mode_mid = M_DQ_BODY;
            M_DQ_BODY:
                if (c == CH_DQUOTE)
                begin
                    a_valid = 1'b1; a_len = span(after, origin_reg);
                    mode_mid = M_IDLE;
                end
            M_SQ_OPEN:
                if (c == CH_SQUOTE)
                begin
                    a_valid = 1'b1; a_kind = KIND_EMPTY; a_len = LEN_W'(2);
                    mode_mid = M_IDLE;
                end
                else mode_mid = M_SQ_BODY;
            M_SQ_BODY:
                if (c == CH_SQUOTE)
                begin
                    a_valid = 1'b1; a_len = span(after, origin_reg);
                    mode_mid = M_IDLE;
                end
            M_WORD:
                if (c == CH_SPACE)
                begin
                    a_valid = 1'b1; a_len = span(pos_reg, origin_reg);
                    mode_mid = M_IDLE;
                end
            default:   start_tok = 1'b1;
        endcase
        if (start_tok)
        begin
            mode_mid = begin_mode(c);
            if (c != CH_SPACE) origin_mid = origin_begin;
        end
    end

    // Line end flush; token B uses the updated origin.
    always_comb
    begin
        b_valid = 1'b0;
        b_kind  = KIND_COMMAND;
        b_len   = LEN_W'(1);
        if (byte_ch.line_end)
        begin
            unique case (mode_mid)
                M_IDLE:    b_valid = 1'b0;
                M_BAR:     begin b_valid = 1'b1; b_kind = KIND_PIPE; end
                M_LT1:     begin b_valid = 1'b1; b_kind = KIND_RIN; end
                M_LT2:
                begin
                    b_valid = 1'b1; b_kind = KIND_HEREDOC; b_len = LEN_W'(2);
                end
                M_GT1:     begin b_valid = 1'b1; b_kind = KIND_ROUT; end
                M_GT2:
                begin
                    b_valid = 1'b1; b_kind = KIND_APPEND; b_len = LEN_W'(2);
                end
                M_DQ_OPEN, M_DQ_BODY, M_SQ_OPEN, M_SQ_BODY:
                begin
                    b_valid = 1'b1; b_kind = KIND_ERROR;
                    b_len = span(after, origin_mid);
                end
                M_WORD:
                begin
                    b_valid = 1'b1; b_len = span(after, origin_mid);
                end
                default:   b_valid = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        q_data.two         = a_valid && b_valid;
        q_data.tok1.kind   = b_kind;
        q_data.tok1.start  = origin_mid;
        q_data.tok1.length = b_len;
        if (a_valid)
        begin
            q_data.tok0.kind   = a_kind;
            q_data.tok0.start  = origin_reg;
            q_data.tok0.length = a_len;
        end
        else
        begin
            q_data.tok0 = q_data.tok1;
        end
    end

    assign q_push = fire && (a_valid || b_valid);

    assign mode_next   = byte_ch.line_end ? M_IDLE : mode_mid;
    assign pos_next    = byte_ch.line_end ? '0 : after;
    assign origin_next = origin_mid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            origin_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            origin_reg <= origin_next;
        end
    end

endmodule

// ===== rtl/sclt_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sclt_queue: short step queue between front and back
// Holds up to QDEPTH step records; head is visible while not empty.
// ============================================================================
module sclt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sclt_pkg::step_t push_data,
    output logic            full,
    input  logic            pop,
    output sclt_pkg::step_t head,
    output logic            empty
);
    import sclt_pkg::*;

    step_t               slots [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    assign wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
    assign rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
    assign count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);

    always_ff @(posedge clk)
    begin
        if (do_push) slots[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/sclt_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sclt_back: token emitter
// Splits each step record into one or two token requests into an output
// register, marking run_last on the final token of the record.
// ============================================================================
module sclt_back (
    input  logic            clk,
    input  logic            rst_n,
    input  sclt_pkg::step_t head,
    input  logic            empty,
    output logic            pop,
    sclt_token_if.source    token_ch
);
    import sclt_pkg::*;

    logic    valid_reg, valid_next;
    logic    sel_reg, sel_next;
    token_t  tok_reg, tok_sel;
    logic    last_reg, last_sel;
    logic    load;

    assign load     = !empty && (!valid_reg || token_ch.ready);
    assign tok_sel  = sel_reg ? head.tok1 : head.tok0;
    assign last_sel = sel_reg || !head.two;
    assign pop      = load && last_sel;

    assign sel_next   = load ? !last_sel : sel_reg;
    assign valid_next = load ? 1'b1 : (token_ch.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_reg  <= tok_sel;
            last_reg <= last_sel;
        end
    end

    assign token_ch.valid        = valid_reg;
    assign token_ch.token_kind   = tok_reg.kind;
    assign token_ch.token_start  = tok_reg.start;
    assign token_ch.token_length = tok_reg.length;
    assign token_ch.run_last     = last_reg;

endmodule

// ===== tb/shell_command_line_tokenizer_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// shell_command_line_tokenizer_checker: token scoreboard for the tokenizer
// Watches both channels, runs its own scanner on every accepted byte, keeps
// the tokens it expects in order and compares each accepted token with them.
// ============================================================================
module shell_command_line_tokenizer_checker
    import sclt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    sclt_byte_if   byte_ch,
    sclt_token_if  token_ch,
    output int     errors,
    output int     tokens_owed
);

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic               last;
    } tok_rec_t;

    tok_rec_t owed_q[$];

    // scanner state
    mode_t              scan_md;
    logic [POS_W-1:0]   seen;
    logic [START_W-1:0] origin;

    tok_rec_t step_tok[2];
    int       step_n;
    int       tok_idx;

    initial begin
        errors      = 0;
        tokens_owed = 0;
        tok_idx     = 0;
    end

    task automatic report(input string msg);
        $display("%0t ns token %0d: MISMATCH %s", $time, tok_idx, msg);
        errors++;
    endtask

    function automatic logic [LEN_W-1:0] span_to(input logic [POS_W-1:0] fin);
        return (fin > POS_W'(origin)) ? fin - POS_W'(origin) : LEN_W'(1);
    endfunction

    task automatic emit(input logic [KIND_W-1:0] kind, input logic [LEN_W-1:0] len);
        if (len < 1)
            len = 1;
        if (len > LINE_MAX)
            len = LEN_W'(LINE_MAX);
        step_tok[step_n] = '{kind, origin, len, 1'b0};
        step_n++;
    endtask

    task automatic open_token(input logic [7:0] c, input logic [POS_W-1:0] pos);
        if (c == CH_SPACE)
        begin
            scan_md = M_IDLE;
            return;
        end
        origin = (pos < LINE_MAX - 1) ? START_W'(pos) : START_W'(LINE_MAX - 1);
        if (c == CH_BAR)
            scan_md = M_BAR;
        else if (c == CH_LT)
            scan_md = M_LT1;
        else if (c == CH_GT)
            scan_md = M_GT1;
        else if (c == CH_DQUOTE)
            scan_md = M_DQ_OPEN;
        else if (c == CH_SQUOTE)
            scan_md = M_SQ_OPEN;
        else
            scan_md = M_WORD;
    endtask

    task automatic scan_byte(input logic [7:0] c, input logic le);
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] after;
        pos    = seen;
        after  = (pos < LINE_MAX) ? pos + 1'b1 : POS_W'(LINE_MAX);
        step_n = 0;

        case (scan_md)
            M_BAR:
                if (c == CH_BAR) scan_md = M_WORD;
                else begin emit(KIND_PIPE, 1); open_token(c, pos); end
            M_LT1:
                if (c == CH_LT) scan_md = M_LT2;
                else begin emit(KIND_RIN, 1); open_token(c, pos); end
            M_LT2:
                if (c == CH_LT) scan_md = M_WORD;
                else begin emit(KIND_HEREDOC, 2); open_token(c, pos); end
            M_GT1:
                if (c == CH_GT) scan_md = M_GT2;
                else begin emit(KIND_ROUT, 1); open_token(c, pos); end
            M_GT2:
                if (c == CH_GT) scan_md = M_WORD;
                else begin emit(KIND_APPEND, 2); open_token(c, pos); end
            M_DQ_OPEN:
                if (c == CH_DQUOTE) begin emit(KIND_EMPTY, 2); scan_md = M_IDLE; end
                else scan_md = M_DQ_BODY;
            M_DQ_BODY:
                if (c == CH_DQUOTE) begin emit(KIND_COMMAND, span_to(after)); scan_md = M_IDLE; end
            M_SQ_OPEN:
                if (c == CH_SQUOTE) begin emit(KIND_EMPTY, 2); scan_md = M_IDLE; end
                else scan_md = M_SQ_BODY;
            M_SQ_BODY:
                if (c == CH_SQUOTE) begin emit(KIND_COMMAND, span_to(after)); scan_md = M_IDLE; end
            M_WORD:
                if (c == CH_SPACE) begin emit(KIND_COMMAND, span_to(pos)); scan_md = M_IDLE; end
            default:
                open_token(c, pos);
        endcase

        seen = after;

        if (le)
        begin
            case (scan_md)
                M_BAR:     emit(KIND_PIPE, 1);
                M_LT1:     emit(KIND_RIN, 1);
                M_LT2:     emit(KIND_HEREDOC, 2);
                M_GT1:     emit(KIND_ROUT, 1);
                M_GT2:     emit(KIND_APPEND, 2);
                M_DQ_OPEN, M_DQ_BODY, M_SQ_OPEN, M_SQ_BODY:
                           emit(KIND_ERROR, span_to(after));
                M_WORD:    emit(KIND_COMMAND, span_to(after));
                default: ;
            endcase
            scan_md = M_IDLE;
            seen    = '0;
        end

        if (step_n > 0)
            step_tok[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            owed_q.push_back(step_tok[i]);
    endtask

    always @(posedge clk)
    begin
        tok_rec_t exp_tok;
        if (!rst_n)
        begin
            scan_md = M_IDLE;
            seen    = '0;
            origin  = '0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
                scan_byte(byte_ch.char_in, byte_ch.line_end);

            if (token_ch.valid && token_ch.ready)
            begin
                if (owed_q.size() == 0)
                    report($sformatf("unexpected token kind %0d start %0d length %0d",
                                     token_ch.token_kind, token_ch.token_start,
                                     token_ch.token_length));
                else
                begin
                    exp_tok = owed_q.pop_front();
                    if (token_ch.token_kind !== exp_tok.kind)
                        report($sformatf("token_kind got %0d exp %0d",
                                         token_ch.token_kind, exp_tok.kind));
                    if (token_ch.token_start !== exp_tok.start)
                        report($sformatf("token_start got %0d exp %0d",
                                         token_ch.token_start, exp_tok.start));
                    if (token_ch.token_length !== exp_tok.length)
                        report($sformatf("token_length got %0d exp %0d",
                                         token_ch.token_length, exp_tok.length));
                    if (token_ch.run_last !== exp_tok.last)
                        report($sformatf("run_last got %0b exp %0b",
                                         token_ch.run_last, exp_tok.last));
                end
                tok_idx++;
            end
        end
        tokens_owed <= owed_q.size();
    end

endmodule

// ===== tb/shell_command_line_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// shell_command_line_tokenizer_tb: stimulus and verdict for the tokenizer
// Feeds directed command lines (operators, doubled and tripled operators,
// quotes, empty quotes, unterminated quotes, trailing spaces, byte extremes),
// then random lines, with random idle bursts on both channels. The checker
// predicts and compares every token.
// ============================================================================
module shell_command_line_tokenizer_tb;
    import sclt_pkg::*;

    logic clk;
    logic rst_n;

    sclt_byte_if  byte_ch();
    sclt_token_if token_ch();

    int errors;
    int tokens_owed;

    // Idle bursts on both sides are enabled per line; cleared for the tail.
    bit gaps_on;
    int bytes_sent;

    shell_command_line_tokenizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .token_ch (token_ch)
    );

    shell_command_line_tokenizer_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_ch     (byte_ch),
        .token_ch    (token_ch),
        .errors      (errors),
        .tokens_owed (tokens_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop; a correct run needs a small fraction of this.
    initial
    begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Token sink: ready drops in random bursts while gaps are on.
    // Only one nonblocking write to ready per clock edge.
    initial
    begin
        token_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                token_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            token_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // One byte request. Called at a clock edge; returns at the edge where
    // the request was taken, so the next call can drive at that same edge.
    task automatic send_byte(input logic [7:0] c, input logic le);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        byte_ch.valid    <= 1'b1;
        byte_ch.char_in  <= c;
        byte_ch.line_end <= le;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // Weighted alphabet: plenty of spaces, operators and quotes so the scanner
    // hits every mode, plus letters and arbitrary nonzero bytes.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0, 1, 2: return CH_SPACE;
            3:       return CH_BAR;
            4:       return CH_LT;
            5:       return CH_GT;
            6:       return CH_DQUOTE;
            7:       return CH_SQUOTE;
            13, 14, 15: return 8'($urandom_range(1, 255));
            default: return 8'($urandom_range(97, 122));
        endcase
    endfunction

    task automatic random_line(input int len);
        for (int i = 0; i < len; i++)
            send_byte(pick_char(), i == len - 1);
    endtask

    // Block until the checker owes nothing or the drain limit runs out. One edge
    // first so that a request taken at the current edge is already counted.
    task automatic drain(input int max_cycles);
        @(posedge clk);
        for (int w = 0; w < max_cycles && tokens_owed != 0; w++)
            @(posedge clk);
    endtask

    initial
    begin
        int  len;
        bit  paused;

        gaps_on    = 1'b0;
        bytes_sent = 0;
        paused     = 1'b0;

        rst_n            <= 1'b0;
        byte_ch.valid    <= 1'b0;
        byte_ch.char_in  <= 8'd0;
        byte_ch.line_end <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed lines ----------------
        // pipe, redir in, then redir out flushed by line end: last byte
        // closes one token and flushes another
        send_line("|<>");
        gaps_on = 1'b1;
        // heredoc followed by append
        send_line("<<>>");
        // tripled '<' and doubled '|' fall back to command words
        send_line("<<< ||");
        // empty double and single quotes, then an unterminated quote
        send_line("\"\"''\"");
        // quoted string with a space inside, trailing space gives nothing
        send_line("'a b' x ");
        // byte extremes as one-byte lines
        send_byte(8'd1, 1'b1);
        send_byte(8'd255, 1'b1);

        // ---------------- random lines ----------------
        gaps_on = 1'b1;

        while (bytes_sent < 700)
        begin
            // Most lines short; some longer to build multi-token lines.
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(20, 60);
            else
                len = $urandom_range(1, 12);

            // Tail of the run goes without any idling.
            if (bytes_sent > 620)
                gaps_on = 1'b0;
            else
                gaps_on = ($urandom_range(0, 3) != 0);

            random_line(len);

            // Mid-run: sender holds off until every owed token has arrived.
            if (!paused && bytes_sent > 400)
            begin
                byte_ch.valid <= 1'b0;
                drain(5000);
                paused = 1'b1;
            end
        end

        byte_ch.valid <= 1'b0;

        // Wait out the owed tokens, then a few cycles for strays.
        drain(5000);
        repeat (20) @(posedge clk);

        if (errors == 0 && tokens_owed == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sclt_pkg.sv
rtl/sclt_ifs.sv
rtl/sclt_front.sv
rtl/sclt_queue.sv
rtl/sclt_back.sv
rtl/shell_command_line_tokenizer.sv
tb/shell_command_line_tokenizer_checker.sv
tb/shell_command_line_tokenizer_tb.sv
